// ===== src/p1305_pkg.sv =====
package p1305_pkg;

  localparam int NumLimbs = 5;
  localparam int LimbW    = 26;
  localparam int HLimbW   = 27;
  localparam int AccW     = 28;
  localparam int SLimbW   = 29;
  localparam int ProdW    = 57;
  localparam int SumW     = 64;
  localparam int MsgW     = 129;
  localparam int KeyW     = 128;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegKeyRLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyRHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyPadLow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyPadHi  = 3'd3;

  localparam logic [KeyW-1:0] ClampMask = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  localparam logic KindStart = 1'b0;

  typedef logic [HLimbW-1:0] hlimb_t;
  typedef hlimb_t [NumLimbs-1:0] hvec_t;

  typedef struct packed {
    logic            start;
    logic            absorb;
    logic            last;
    logic [MsgW-1:0] msg;
  } blk_t;

  typedef struct packed {
    logic  launch;
    hvec_t h;
  } tag_req_t;

endpackage

// ===== src/p1305_front.sv =====
module p1305_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [63:0]           in_word_low,
  input  logic [63:0]           in_word_high,
  input  logic [4:0]            in_byte_count,
  input  logic                  in_last,
  output logic                  q_valid,
  output p1305_pkg::blk_t       q_data,
  input  logic                  q_pop
);
  import p1305_pkg::*;

  localparam int Depth = 2;

  blk_t         blk;
  blk_t         q_r [Depth];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push;
  logic [127:0] word;
  logic [6:0]   sh;
  logic [127:0] mask;

  // turn the item into a padded 129-bit block
  always_comb begin
    word       = {in_word_high, in_word_low};
    sh         = {in_byte_count[3:0], 3'b000};
    mask       = (128'd1 << sh) - 128'd1;
    blk.last   = in_last;
    blk.start  = (in_kind == KindStart);
    blk.absorb = 1'b1;
    blk.msg    = {1'b1, word};
    if (in_kind != KindStart && !in_byte_count[4]) begin
      if (in_byte_count == 5'd0) begin
        blk.absorb = 1'b0;
      end else begin
        blk.msg = {1'b0, (word & mask) | (128'd1 << sh)};
      end
    end
  end

  assign in_stall = (cnt_r == 2'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= blk;
    end
  end

endmodule

// ===== src/p1305_core.sv =====
module p1305_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [127:0]          key_r,
  input  logic                  q_valid,
  input  p1305_pkg::blk_t       q_data,
  output logic                  q_pop,
  input  logic                  tag_busy,
  output p1305_pkg::tag_req_t   tag_req
);
  import p1305_pkg::*;

  localparam logic [1:0] CS_IDLE  = 2'd0;
  localparam logic [1:0] CS_MUL   = 2'd1;
  localparam logic [1:0] CS_CARRY = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [2:0]            step_r, step_nxt;
  logic                  last_r, last_nxt;
  hvec_t                 h_r, h_nxt, h_calc;
  logic [AccW-1:0]       a_r [NumLimbs];
  logic [SumW-1:0]       d_r [NumLimbs];
  logic [KeyW-1:0]       rc;
  logic [LimbW-1:0]      r_l [NumLimbs];
  logic [SLimbW-1:0]     s_l [NumLimbs];
  logic [SLimbW-1:0]     op  [NumLimbs];
  logic [ProdW-1:0]      prod [NumLimbs];
  logic [SumW-1:0]       t;
  logic [SumW-1:0]       c;
  logic [LimbW-1:0]      hl [NumLimbs];
  logic                  load;

  always_comb begin
    rc = key_r & ClampMask;
    for (int k = 0; k < NumLimbs; k++) begin
      if (k == NumLimbs - 1) begin
        r_l[k] = LimbW'(rc[KeyW-1:LimbW*(NumLimbs-1)]);
      end else begin
        r_l[k] = rc[LimbW*k +: LimbW];
      end
      s_l[k] = SLimbW'({r_l[k], 2'b00}) + SLimbW'(r_l[k]);
    end
  end

  // one limb of a times every limb of r per cycle, wrapped terms use 5*r
  always_comb begin
    for (int k = 0; k < NumLimbs; k++) begin
      if (k >= int'(step_r)) begin
        op[k] = SLimbW'(r_l[3'(k - int'(step_r))]);
      end else begin
        op[k] = s_l[3'(k + NumLimbs - int'(step_r))];
      end
      prod[k] = a_r[step_r] * op[k];
    end
  end

  // carry chain back to 26-bit limbs
  always_comb begin
    t     = d_r[0];
    hl[0] = t[LimbW-1:0];
    c     = t >> LimbW;
    for (int k = 1; k < NumLimbs; k++) begin
      t     = d_r[k] + c;
      hl[k] = t[LimbW-1:0];
      c     = t >> LimbW;
    end
    t = SumW'(hl[0]) + (c << 2) + c;
    for (int k = 0; k < NumLimbs; k++) begin
      h_calc[k] = HLimbW'(hl[k]);
    end
    h_calc[0] = HLimbW'(t[LimbW-1:0]);
    h_calc[1] = HLimbW'(hl[1]) + HLimbW'(t >> LimbW);
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    last_nxt       = last_r;
    h_nxt          = h_r;
    q_pop          = 1'b0;
    load           = 1'b0;
    tag_req.launch = 1'b0;
    tag_req.h      = h_r;
    case (state_r)
      CS_IDLE: begin
        if (q_valid) begin
          if (q_data.absorb) begin
            q_pop     = 1'b1;
            load      = 1'b1;
            last_nxt  = q_data.last;
            step_nxt  = 3'd0;
            state_nxt = CS_MUL;
          end else if (!q_data.last) begin
            q_pop = 1'b1;
          end else if (!tag_busy) begin
            q_pop          = 1'b1;
            tag_req.launch = 1'b1;
          end
        end
      end
      CS_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(NumLimbs - 1)) begin
          state_nxt = CS_CARRY;
        end
      end
      CS_CARRY: begin
        if (!(last_r && tag_busy)) begin
          h_nxt          = h_calc;
          tag_req.launch = last_r;
          tag_req.h      = h_calc;
          state_nxt      = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      step_r  <= 3'd0;
      last_r  <= 1'b0;
      h_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NumLimbs; k++) begin
        if (k == NumLimbs - 1) begin
          a_r[k] <= (q_data.start ? AccW'(0) : AccW'(h_r[k]))
                    + AccW'(q_data.msg[MsgW-1:LimbW*(NumLimbs-1)]);
        end else begin
          a_r[k] <= (q_data.start ? AccW'(0) : AccW'(h_r[k]))
                    + AccW'(q_data.msg[LimbW*k +: LimbW]);
        end
      end
    end
    if (state_r == CS_MUL) begin
      for (int k = 0; k < NumLimbs; k++) begin
        d_r[k] <= (step_r == 3'd0) ? SumW'(prod[k]) : d_r[k] + SumW'(prod[k]);
      end
    end
  end

endmodule

// ===== src/p1305_tag.sv =====
module p1305_tag (
  input  logic                  clk,
  input  logic                  rst_n,
  input  p1305_pkg::tag_req_t   tag_req,
  input  logic [127:0]          key_pad,
  output logic                  tag_busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [127:0]          tag
);
  import p1305_pkg::*;

  localparam logic [2:0] TG_IDLE  = 3'd0;
  localparam logic [2:0] TG_PASS1 = 3'd1;
  localparam logic [2:0] TG_PASS2 = 3'd2;
  localparam logic [2:0] TG_JOIN  = 3'd3;
  localparam logic [2:0] TG_SEL   = 3'd4;
  localparam logic [2:0] TG_PAD   = 3'd5;

  logic [2:0]   st_r, st_nxt;
  logic         valid_r, valid_nxt;
  hvec_t        h_r;
  logic [131:0] v_r;
  logic [131:0] g;
  logic [127:0] res_r;
  logic [127:0] tag_r;

  function automatic hvec_t carry_pass(input hvec_t hi);
    hvec_t       ho;
    logic [31:0] w;
    logic [31:0] c;
    begin
      ho = hi;
      c  = 32'(ho[1]) >> LimbW;
      ho[1] = HLimbW'(ho[1][LimbW-1:0]);
      for (int k = 2; k < NumLimbs; k++) begin
        w     = 32'(ho[k]) + c;
        ho[k] = HLimbW'(w[LimbW-1:0]);
        c     = w >> LimbW;
      end
      w     = 32'(ho[0]) + (c << 2) + c;
      ho[0] = HLimbW'(w[LimbW-1:0]);
      ho[1] = ho[1] + HLimbW'(w >> LimbW);
      carry_pass = ho;
    end
  endfunction

  assign g = v_r + 132'd5;

  always_comb begin
    st_nxt    = st_r;
    valid_nxt = valid_r && out_stall;
    case (st_r)
      TG_IDLE:  if (tag_req.launch) st_nxt = TG_PASS1;
      TG_PASS1: st_nxt = TG_PASS2;
      TG_PASS2: st_nxt = TG_JOIN;
      TG_JOIN:  st_nxt = TG_SEL;
      TG_SEL:   st_nxt = TG_PAD;
      TG_PAD: begin
        st_nxt    = TG_IDLE;
        valid_nxt = 1'b1;
      end
      default:  st_nxt = TG_IDLE;
    endcase
  end

  assign tag_busy  = (st_r != TG_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign tag       = tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= TG_IDLE;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      TG_IDLE:  if (tag_req.launch) h_r <= tag_req.h;
      TG_PASS1: h_r <= carry_pass(h_r);
      TG_PASS2: h_r <= carry_pass(h_r);
      TG_JOIN: begin
        v_r <= {2'b00, h_r[4][LimbW-1:0], h_r[3][LimbW-1:0], h_r[2][LimbW-1:0],
                h_r[1][LimbW-1:0], h_r[0][LimbW-1:0]}
               + (132'(h_r[1][LimbW]) << (2 * LimbW));
      end
      // value is below 2p here, one conditional subtract of p
      TG_SEL:   res_r <= (g[131:130] != 2'b00) ? g[127:0] : v_r[127:0];
      TG_PAD:   tag_r <= res_r + key_pad;
      default: begin
      end
    endcase
  end

endmodule

// ===== src/poly1305_mac_engine.sv =====
// a last item's tag reaches out_valid via the core's multiply and carry states
// and the tag unit's passes, join, select and pad; the shared 5-lane multiplier
// (5 product rows) works on one 16-byte block at a time, between load and carry
// a 2-entry queue accepts items while the core and tag unit are busy
// reset: synchronous active-low rst_n clears accumulator, key registers and queue
module poly1305_mac_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_word_low,
  input  logic [63:0] in_word_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_tag_low,
  output logic [63:0] out_tag_high
);
  import p1305_pkg::*;

  logic [CfgW-1:0] key_r_low_r, key_r_high_r, key_pad_low_r, key_pad_high_r;
  logic            q_valid;
  blk_t            q_data;
  logic            q_pop;
  logic            tag_busy;
  tag_req_t        tag_req;
  logic [127:0]    tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r_low_r    <= '0;
      key_r_high_r   <= '0;
      key_pad_low_r  <= '0;
      key_pad_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyRLow:   key_r_low_r    <= cfg_wdata;
        RegKeyRHigh:  key_r_high_r   <= cfg_wdata;
        RegKeyPadLow: key_pad_low_r  <= cfg_wdata;
        RegKeyPadHi:  key_pad_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  p1305_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_word_low  (in_word_low),
    .in_word_high (in_word_high),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  p1305_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_r    ({key_r_high_r, key_r_low_r}),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .tag_busy (tag_busy),
    .tag_req  (tag_req)
  );

  p1305_tag u_tag (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_req  (tag_req),
    .key_pad  ({key_pad_high_r, key_pad_low_r}),
    .tag_busy (tag_busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tag      (tag)
  );

  assign out_tag_low  = tag[63:0];
  assign out_tag_high = tag[127:64];

endmodule
